/* rtl/core/mtep_pkg.sv */
// Shared types and constants for the track-chunk event parser.
// Used by mtep_step and midi_track_event_parser; no dependencies.
package mtep_pkg;

  localparam int LENGTH_BITS = 28;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // Parse phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_DELTA   = 3'd1,
    PH_STATUS  = 3'd2,
    PH_DATA1   = 3'd3,
    PH_DATA2   = 3'd4,
    PH_MTYPE   = 3'd5,
    PH_LEN     = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_t;

  // Result kinds
  localparam logic [3:0] K_NOTEOFF = 4'd0;
  localparam logic [3:0] K_PROGRAM = 4'd4;
  localparam logic [3:0] K_CHPRESS = 4'd5;
  localparam logic [3:0] K_PITCH   = 4'd6;
  localparam logic [3:0] K_META    = 4'd7;
  localparam logic [3:0] K_SYSEX   = 4'd8;
  localparam logic [3:0] K_PAYLOAD = 4'd9;
  localparam logic [3:0] K_NONE    = 4'd15;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] ST_CHAN_LO  = 8'h80;
  localparam logic [7:0] ST_CHAN_HI  = 8'hEF;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  hdr_pos;
    logic        hdr_ok;
    len_t        delta;
    logic [3:0]  run_kind;
    logic [3:0]  run_chan;
    logic [7:0]  held;
    len_t        len_acc;
    len_t        remaining;
    logic        end_pending;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  kind;
    len_t        delta_time;
    logic [3:0]  channel;
    logic [7:0]  first_value;
    logic [13:0] second_value;
    len_t        payload_length;
    logic        payload_last;
    logic        track_ended;
  } result_t;

  // Chunk id "MTrk", one byte per header position
  function automatic logic [7:0] mtrk_byte(input logic [1:0] pos);
    case (pos)
      2'd0:    mtrk_byte = 8'h4D;
      2'd1:    mtrk_byte = 8'h54;
      2'd2:    mtrk_byte = 8'h72;
      default: mtrk_byte = 8'h6B;
    endcase
  endfunction

  // Variable-length quantity step with saturation
  function automatic len_t vlq_add(input len_t acc, input logic [7:0] b);
    if (acc[LENGTH_BITS-1:LENGTH_BITS-7] != 7'd0) begin
      vlq_add = '1;
    end else begin
      vlq_add = {acc[LENGTH_BITS-8:0], b[6:0]};
    end
  endfunction

endpackage

/* rtl/core/mtep_step.sv */
// Next-state and result logic for one stream byte of the track parser.
// Purely combinational; depends on mtep_pkg.
module mtep_step import mtep_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   byte_value,
  output parse_state_t nx,
  output logic         res_valid,
  output result_t      res
);

  logic do_first;
  logic do_len;
  logic len_from_zero;
  len_t len_new;
  logic is_meta;
  logic eot;
  logic pay_last;

  assign is_meta  = (st.run_kind == K_META);
  assign eot      = is_meta && (st.held == META_EOT);
  assign pay_last = (st.remaining <= len_t'(1));

  always_comb begin
    nx            = st;
    res_valid     = 1'b0;
    res           = '0;
    do_first      = 1'b0;
    do_len        = 1'b0;
    len_from_zero = 1'b0;

    case (st.phase)
      PH_HEADER: begin
        if (!st.hdr_pos[2] && byte_value != mtrk_byte(st.hdr_pos[1:0])) begin
          nx.hdr_ok = 1'b0;
        end
        if (st.hdr_pos == 3'd7) begin
          nx.hdr_pos = '0;
          nx.hdr_ok  = 1'b1;
          if (st.hdr_ok) begin
            nx.run_kind = K_NONE;
            nx.phase    = PH_DELTA;
            nx.delta    = '0;
          end
        end else begin
          nx.hdr_pos = st.hdr_pos + 3'd1;
        end
      end
      PH_DELTA: begin
        nx.delta = vlq_add(st.delta, byte_value);
        if (!byte_value[7]) nx.phase = PH_STATUS;
      end
      PH_STATUS: begin
        if (byte_value[7]) begin
          if (byte_value == ST_META) begin
            nx.run_kind = K_META;
            nx.phase    = PH_MTYPE;
          end else if (byte_value == ST_SYSEX || byte_value == ST_SYSEX_CT) begin
            nx.run_kind = K_SYSEX;
            nx.len_acc  = '0;
            nx.phase    = PH_LEN;
          end else if (byte_value inside {[ST_CHAN_LO:ST_CHAN_HI]}) begin
            nx.run_kind = {1'b0, byte_value[6:4]};
            nx.run_chan = byte_value[3:0];
            nx.phase    = PH_DATA1;
          end else begin
            // undefined system status: drop the event
            nx.phase = PH_DELTA;
            nx.delta = '0;
          end
        end else if (st.run_kind == K_NONE) begin
          nx.phase = PH_DELTA;
          nx.delta = '0;
        end else if (st.run_kind == K_META) begin
          nx.held    = byte_value;
          nx.len_acc = '0;
          nx.phase   = PH_LEN;
        end else if (st.run_kind == K_SYSEX) begin
          // running sysex: this byte is the whole length
          do_len        = 1'b1;
          len_from_zero = 1'b1;
        end else begin
          do_first = 1'b1;
        end
      end
      PH_DATA1: do_first = 1'b1;
      PH_DATA2: begin
        res_valid        = 1'b1;
        res.kind         = st.run_kind;
        res.delta_time   = st.delta;
        res.channel      = st.run_chan;
        res.first_value  = st.held;
        res.second_value = (st.run_kind == K_PITCH) ? {byte_value[6:0], st.held[6:0]}
                                                    : {6'd0, byte_value};
        nx.phase = PH_DELTA;
        nx.delta = '0;
      end
      PH_MTYPE: begin
        nx.held    = byte_value;
        nx.len_acc = '0;
        nx.phase   = PH_LEN;
      end
      PH_LEN: do_len = 1'b1;
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = K_PAYLOAD;
        res.first_value  = byte_value;
        res.payload_last = pay_last;
        res.track_ended  = pay_last && st.end_pending;
        if (pay_last) begin
          nx.remaining = '0;
          if (st.end_pending) begin
            nx.end_pending = 1'b0;
            nx.phase       = PH_HEADER;
            nx.hdr_pos     = '0;
            nx.hdr_ok      = 1'b1;
          end else begin
            nx.phase = PH_DELTA;
            nx.delta = '0;
          end
        end else begin
          nx.remaining = st.remaining - len_t'(1);
        end
      end
      default: begin
        nx.phase   = PH_HEADER;
        nx.hdr_pos = '0;
        nx.hdr_ok  = 1'b1;
      end
    endcase

    if (do_first) begin
      if (st.run_kind inside {K_PROGRAM, K_CHPRESS}) begin
        res_valid       = 1'b1;
        res.kind        = st.run_kind;
        res.delta_time  = st.delta;
        res.channel     = st.run_chan;
        res.first_value = byte_value;
        nx.phase        = PH_DELTA;
        nx.delta        = '0;
      end else begin
        nx.held  = byte_value;
        nx.phase = PH_DATA2;
      end
    end

    len_new = vlq_add(len_from_zero ? '0 : st.len_acc, byte_value);

    if (do_len) begin
      nx.len_acc = len_new;
      if (!byte_value[7]) begin
        res_valid       = 1'b1;
        res.kind        = is_meta ? K_META : K_SYSEX;
        res.delta_time  = st.delta;
        res.first_value = is_meta ? st.held : 8'd0;
        if (len_new == '0) begin
          res.track_ended = eot;
          if (eot) begin
            nx.phase   = PH_HEADER;
            nx.hdr_pos = '0;
            nx.hdr_ok  = 1'b1;
          end else begin
            nx.phase = PH_DELTA;
            nx.delta = '0;
          end
        end else begin
          res.payload_length = len_new;
          nx.remaining       = len_new;
          nx.end_pending     = eot;
          nx.phase           = PH_PAYLOAD;
        end
      end
    end
  end

endmodule

/* rtl/core/midi_track_event_parser.sv */
// Track-chunk event parser: one stream byte in per beat, at most one event
// or payload-byte result out. A result appears on out_* in the cycle after
// the byte that completes it is accepted. Throughput: one byte per cycle
// while in_stall is low, set by the single parse-state register and the result register.
// Synchronous active-low reset returns to chunk-header search.
// Depends on mtep_pkg and mtep_step.
module midi_track_event_parser import mtep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [27:0] out_delta_time,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_first_value,
  output logic [13:0] out_second_value,
  output logic [27:0] out_payload_length,
  output logic        out_payload_last,
  output logic        out_track_ended
);

  parse_state_t st_r, st_nxt;
  result_t      res_r, res_nxt;
  logic         out_valid_r;
  logic         res_valid;
  logic         in_take;

  // hold off input only while a result beat sits unconsumed
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  mtep_step u_step (
    .st         (st_r),
    .byte_value (in_byte_value),
    .nx         (st_nxt),
    .res_valid  (res_valid),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_HEADER;
      st_r.hdr_pos     <= '0;
      st_r.hdr_ok      <= 1'b1;
      st_r.delta       <= '0;
      st_r.run_kind    <= K_NONE;
      st_r.run_chan    <= '0;
      st_r.held        <= '0;
      st_r.len_acc     <= '0;
      st_r.remaining   <= '0;
      st_r.end_pending <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_take) st_r <= st_nxt;
      if (!in_stall) out_valid_r <= in_take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_valid) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = res_r.kind;
  assign out_delta_time     = res_r.delta_time;
  assign out_channel        = res_r.channel;
  assign out_first_value    = res_r.first_value;
  assign out_second_value   = res_r.second_value;
  assign out_payload_length = res_r.payload_length;
  assign out_payload_last   = res_r.payload_last;
  assign out_track_ended    = res_r.track_ended;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for midi_track_event_parser, with an event scoreboard
// that decodes every accepted byte on its own. Depends on mtep_pkg and the parser RTL.
module tb_top import mtep_pkg::*; ();

  localparam logic [63:0] LEN_MAX   = (64'd1 << LENGTH_BITS) - 1;
  localparam logic [31:0] TRACK_ID  = 32'h4D54726B;
  localparam int          MAX_SHOWN = 10;

  localparam logic [3:0] KIND_NOTEON  = 4'd1;
  localparam logic [3:0] KIND_POLY    = 4'd2;
  localparam logic [3:0] KIND_CONTROL = 4'd3;

  localparam logic [7:0] META_TEXT      = 8'h01;
  localparam logic [7:0] META_NAME      = 8'h03;
  localparam logic [7:0] ST_UNDEF_FIRST = 8'hF1;
  localparam logic [7:0] ST_UNDEF_LAST  = 8'hFE;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;

  class track_event_scoreboard;
    phase_t      phase;
    int unsigned hdr_pos;
    bit          hdr_ok;
    logic [63:0] delta_acc;
    logic [3:0]  run_kind;
    logic [3:0]  run_chan;
    logic [7:0]  held;
    logic [63:0] len_acc;
    logic [63:0] remaining;
    bit          end_pending;
    result_t     pending_events[$];
    int          mismatches;

    function new();
      start_header();
      delta_acc   = 0;
      run_kind    = K_NONE;
      run_chan    = 0;
      held        = 0;
      len_acc     = 0;
      remaining   = 0;
      end_pending = 0;
      mismatches  = 0;
    endfunction

    function void start_header();
      phase   = PH_HEADER;
      hdr_pos = 0;
      hdr_ok  = 1;
    endfunction

    function void start_delta();
      phase     = PH_DELTA;
      delta_acc = 0;
    endfunction

    function logic [63:0] vlq(input logic [63:0] acc, input logic [7:0] b);
      logic [63:0] v;
      v = (acc << 7) | {57'd0, b[6:0]};
      return (v > LEN_MAX) ? LEN_MAX : v;
    endfunction

    function result_t make(input logic [3:0] kind, input logic [63:0] dt,
                           input logic [3:0] chan, input logic [7:0] v1,
                           input logic [13:0] v2, input logic [63:0] plen,
                           input bit last, input bit ended);
      result_t r;
      r.kind           = kind;
      r.delta_time     = dt[LENGTH_BITS-1:0];
      r.channel        = chan;
      r.first_value    = v1;
      r.second_value   = v2;
      r.payload_length = plen[LENGTH_BITS-1:0];
      r.payload_last   = last;
      r.track_ended    = ended;
      return r;
    endfunction

    function bit first_data(input logic [7:0] b, output result_t r);
      r = '0;
      if (run_kind == K_PROGRAM || run_kind == K_CHPRESS) begin
        r = make(run_kind, delta_acc, run_chan, b, 14'd0, 64'd0, 1'b0, 1'b0);
        start_delta();
        return 1;
      end
      held  = b;
      phase = PH_DATA2;
      return 0;
    endfunction

    // length byte of a meta or sysex event
    function bit take_length(input logic [7:0] b, output result_t r);
      bit is_meta;
      bit eot;
      r = '0;
      len_acc = vlq(len_acc, b);
      if (b[7]) return 0;
      is_meta = (run_kind == K_META);
      eot     = is_meta && held == META_EOT;
      if (len_acc == 0) begin
        r = make(is_meta ? K_META : K_SYSEX, delta_acc, 4'd0, is_meta ? held : 8'd0,
                 14'd0, 64'd0, 1'b0, eot);
        if (eot) start_header();
        else start_delta();
      end else begin
        r = make(is_meta ? K_META : K_SYSEX, delta_acc, 4'd0, is_meta ? held : 8'd0,
                 14'd0, len_acc, 1'b0, 1'b0);
        remaining   = len_acc;
        end_pending = eot;
        phase       = PH_PAYLOAD;
      end
      return 1;
    endfunction

    function bit decode_byte(input logic [7:0] b, output result_t r);
      bit ok;
      bit last;
      logic [13:0] second;
      r = '0;
      case (phase)
        PH_HEADER: begin
          if (hdr_pos < 4 && b != TRACK_ID[31-8*hdr_pos -: 8]) hdr_ok = 0;
          if (hdr_pos >= 7) begin
            ok = hdr_ok;
            start_header();
            if (ok) begin
              run_kind = K_NONE;
              start_delta();
            end
          end else begin
            hdr_pos++;
          end
          return 0;
        end
        PH_DELTA: begin
          delta_acc = vlq(delta_acc, b);
          if (!b[7]) phase = PH_STATUS;
          return 0;
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b == ST_META) begin
              run_kind = K_META;
              phase    = PH_MTYPE;
            end else if (b == ST_SYSEX || b == ST_SYSEX_CT) begin
              run_kind = K_SYSEX;
              len_acc  = 0;
              phase    = PH_LEN;
            end else if (b <= ST_CHAN_HI) begin
              run_kind = b[7:4] - ST_CHAN_LO[7:4];
              run_chan = b[3:0];
              phase    = PH_DATA1;
            end else begin
              start_delta();
            end
            return 0;
          end
          if (run_kind == K_NONE) begin
            start_delta();
            return 0;
          end
          if (run_kind == K_META) begin
            held    = b;
            len_acc = 0;
            phase   = PH_LEN;
            return 0;
          end
          if (run_kind == K_SYSEX) begin
            // running sysex: this byte is the whole length
            len_acc = 0;
            phase   = PH_LEN;
            return take_length(b, r);
          end
          return first_data(b, r);
        end
        PH_DATA1: return first_data(b, r);
        PH_DATA2: begin
          if (run_kind == K_PITCH) second = {b[6:0], held[6:0]};
          else second = {6'd0, b};
          r = make(run_kind, delta_acc, run_chan, held, second, 64'd0, 1'b0, 1'b0);
          start_delta();
          return 1;
        end
        PH_MTYPE: begin
          held    = b;
          len_acc = 0;
          phase   = PH_LEN;
          return 0;
        end
        PH_LEN: return take_length(b, r);
        default: begin
          last = (remaining <= 1);
          r = make(K_PAYLOAD, 64'd0, 4'd0, b, 14'd0, 64'd0, last, last && end_pending);
          if (last) begin
            remaining = 0;
            if (end_pending) begin
              end_pending = 0;
              start_header();
            end else begin
              start_delta();
            end
          end else begin
            remaining--;
          end
          return 1;
        end
      endcase
    endfunction

    function void note_byte(input logic [7:0] b);
      result_t r;
      if (decode_byte(b, r)) pending_events = {pending_events, r};
    endfunction

    function void check_event(input result_t got);
      result_t exp;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result beat: kind=%0d dt=%0d ch=%0d v1=%0h v2=%0h",
                   got.kind, got.delta_time, got.channel, got.first_value,
                   got.second_value);
        return;
      end
      exp = pending_events.pop_front();
      if (got.kind !== exp.kind || got.delta_time !== exp.delta_time ||
          got.channel !== exp.channel || got.first_value !== exp.first_value ||
          got.second_value !== exp.second_value ||
          got.payload_length !== exp.payload_length ||
          got.payload_last !== exp.payload_last ||
          got.track_ended !== exp.track_ended) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("event mismatch: expected kind=%0d dt=%0d ch=%0d v1=%0h v2=%0h",
                   exp.kind, exp.delta_time, exp.channel, exp.first_value,
                   exp.second_value, " len=%0d last=%0b end=%0b",
                   exp.payload_length, exp.payload_last, exp.track_ended);
          $display("                  actual kind=%0d dt=%0d ch=%0d v1=%0h v2=%0h",
                   got.kind, got.delta_time, got.channel, got.first_value,
                   got.second_value, " len=%0d last=%0b end=%0b",
                   got.payload_length, got.payload_last, got.track_ended);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_kind;
  logic [27:0] out_delta_time;
  logic [3:0]  out_channel;
  logic [7:0]  out_first_value;
  logic [13:0] out_second_value;
  logic [27:0] out_payload_length;
  logic        out_payload_last;
  logic        out_track_ended;

  bit calm = 1'b0;
  int sent_bytes = 0;
  int gen_run = -1;   // generator's view of running status: -1 none, 0..6 channel, 7, 8
  track_event_scoreboard sb = new();

  midi_track_event_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_value      (in_byte_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_delta_time     (out_delta_time),
    .out_channel        (out_channel),
    .out_first_value    (out_first_value),
    .out_second_value   (out_second_value),
    .out_payload_length (out_payload_length),
    .out_payload_last   (out_payload_last),
    .out_track_ended    (out_track_ended)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind           = out_kind;
      got.delta_time     = out_delta_time;
      got.channel        = out_channel;
      got.first_value    = out_first_value;
      got.second_value   = out_second_value;
      got.payload_length = out_payload_length;
      got.payload_last   = out_payload_last;
      got.track_ended    = out_track_ended;
      sb.check_event(got);
    end
  end

  function automatic logic [7:0] chan_status(input logic [3:0] kind, input logic [3:0] chan);
    return {ST_CHAN_LO[7:4] + kind, chan};
  endfunction

  // mostly 7-bit data, now and then with the top bit set
  function automatic logic [7:0] data_byte(input bit allow_high);
    if (allow_high && $urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(127));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  task automatic send_header(input bit good);
    logic [31:0] id;
    id = TRACK_ID;
    if (!good) id[8*$urandom_range(3) +: 8] ^= 8'(1 + $urandom_range(254));
    for (int p = 0; p < 4; p++) send_byte(id[31-8*p -: 8]);
    for (int p = 0; p < 4; p++) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_delta();
    int pick;
    int n;
    pick = $urandom_range(99);
    n = (pick < 70) ? 1 : (pick < 90) ? $urandom_range(3, 2) : (pick < 95) ? 4 :
        $urandom_range(6, 5);
    repeat (n - 1) send_byte(8'h80 | 8'($urandom_range(127)));
    send_byte(8'($urandom_range(127)));
  endtask

  task automatic send_payload(input bit allow_wide);
    int n;
    n = $urandom_range(5);
    if (allow_wide && $urandom_range(9) == 0) send_byte(8'h80);
    send_byte(8'(n));
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_channel(input int kind, input bit running);
    if (running) send_byte(data_byte(1'b0));
    else begin
      send_byte(chan_status(4'(kind), 4'($urandom_range(15))));
      send_byte(data_byte(1'b1));
    end
    if (kind != K_PROGRAM && kind != K_CHPRESS) send_byte(data_byte(1'b1));
  endtask

  function automatic logic [7:0] meta_type(input bit seven_bit);
    logic [7:0] t;
    t = seven_bit ? 8'($urandom_range(127)) : 8'($urandom_range(255));
    return (t == META_EOT) ? META_TEXT : t;
  endfunction

  task automatic send_event();
    int pick;
    int kind;
    logic [7:0] st;
    send_delta();
    pick = $urandom_range(99);
    if (pick < 45) begin
      kind = $urandom_range(6);
      send_channel(kind, 1'b0);
      gen_run = kind;
    end else if (pick < 58) begin
      send_byte(ST_META);
      send_byte(meta_type(1'b0));
      send_payload(1'b1);
      gen_run = int'(K_META);
    end else if (pick < 70) begin
      send_byte($urandom_range(1) ? ST_SYSEX : ST_SYSEX_CT);
      send_payload(1'b1);
      gen_run = int'(K_SYSEX);
    end else if (pick < 76) begin
      st = 8'($urandom_range(ST_UNDEF_LAST, ST_UNDEF_FIRST));
      if (st == ST_SYSEX_CT) st = ST_TUNE_REQ;
      send_byte(st);
    end else if (gen_run < 0) begin
      send_byte(data_byte(1'b0));
    end else if (gen_run == K_META) begin
      send_byte(meta_type(1'b1));
      send_payload(1'b1);
    end else if (gen_run == K_SYSEX) begin
      send_payload(1'b0);
    end else begin
      send_channel(gen_run, 1'b1);
    end
  endtask

  task automatic send_track();
    int n;
    if ($urandom_range(99) < 15) send_header(1'b0);
    send_header(1'b1);
    gen_run = -1;
    repeat ($urandom_range(20, 3)) send_event();
    send_delta();
    send_byte(ST_META);
    send_byte(META_EOT);
    n = ($urandom_range(99) < 70) ? 0 : $urandom_range(3, 1);
    send_byte(8'(n));
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    int guard;
    directed_bytes = '{
      TRACK_ID[31:24], TRACK_ID[23:16], TRACK_ID[15:8], TRACK_ID[7:0],
      8'h00, 8'h00, 8'h00, 8'h40,
      8'h00, chan_status(KIND_NOTEON, 4'h0), 8'h3C, 8'h64,
      8'h00, 8'h3C, 8'h00,
      8'h00, chan_status(K_PITCH, 4'hF), 8'hFF, 8'h80,
      8'h81, 8'h80, 8'h00, chan_status(K_PROGRAM, 4'h5), 8'hFF,
      8'h00, chan_status(KIND_CONTROL, 4'h2), 8'h07, 8'h7F,
      8'h00, 8'h0A, 8'h40,
      8'h00, ST_TUNE_REQ,
      8'h00, chan_status(K_CHPRESS, 4'h9), 8'h55,
      8'h00, ST_META, META_NAME, 8'h02, 8'h41, 8'h42,
      8'h00, ST_SYSEX, 8'h01, ST_SYSEX_CT,
      8'h00, 8'h02, 8'h11, 8'hEE,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, chan_status(K_NOTEOFF, 4'h1), 8'h40, 8'h00,
      8'h00, ST_META, META_EOT, 8'h00,
      TRACK_ID[31:24], TRACK_ID[23:16], TRACK_ID[15:8], 8'h6C,
      8'h00, 8'h00, 8'h00, 8'h00,
      TRACK_ID[31:24], TRACK_ID[23:16], TRACK_ID[15:8], TRACK_ID[7:0],
      8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h00, 8'h40,
      8'h00, chan_status(KIND_POLY, 4'h3), 8'h3C, 8'h7F,
      8'h00, ST_META, META_TEXT, 8'h00,
      8'h00, 8'h05, 8'h00,
      8'h00, ST_META, META_EOT, 8'h01, 8'hAA
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    sent_bytes = 0;
    while (sent_bytes < 1000) begin
      calm = (sent_bytes >= 400 && sent_bytes < 650);
      send_track();
    end
    calm = 1'b0;

    // saturated payload length, left open at the end of the run
    send_header(1'b1);
    send_byte(8'h00);
    send_byte(ST_META);
    send_byte(META_TEXT);
    repeat (4) send_byte(8'hFF);
    send_byte(8'h7F);
    repeat (6) send_byte(8'($urandom_range(255)));
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending_events.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_events.size() == 0 && sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
